>>> hdl/tabi_pkg.sv
// ---------------------------------------------------------------------------
// tabi_pkg
// shared types and codes for the timestamped heading store
// ---------------------------------------------------------------------------
package tabi_pkg;

  localparam int STAMP_W = 48;
  localparam int ANGLE_W = 16;
  localparam int MAG_W   = 17;   // magnitude of a short-way angle step
  localparam int TOL_W   = 32;
  localparam int LIM_W   = 11;

  // item kinds
  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAN = 2'd2;

  // result outcomes
  localparam logic [2:0] OUT_INTERP = 3'd0;
  localparam logic [2:0] OUT_FIRST  = 3'd1;
  localparam logic [2:0] OUT_LAST   = 3'd2;
  localparam logic [2:0] OUT_EMPTY  = 3'd3;
  localparam logic [2:0] OUT_TOL    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_TOLERANCE = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_KEEP      = 2'd3;

  typedef struct packed {
    logic [1:0]                kind;
    logic [STAMP_W-1:0]        stamp_us;
    logic signed [ANGLE_W-1:0] angle_in;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_out;
    logic [2:0]                outcome;
  } out_item_t;

  // handshake between the sequencer and the fraction unit
  typedef struct packed {
    logic busy;
    logic done;
  } frac_status_t;

endpackage

>>> hdl/tabi_frac.sv
// ---------------------------------------------------------------------------
// tabi_frac
// serial unit for floor(mag * num / den), one bit of mag per cycle
// ---------------------------------------------------------------------------
module tabi_frac (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tabi_pkg::MAG_W-1:0]     mag,
  input  logic [tabi_pkg::STAMP_W-1:0]   num,
  input  logic [tabi_pkg::STAMP_W-1:0]   den,
  output tabi_pkg::frac_status_t         status,
  output logic [tabi_pkg::MAG_W-1:0]     quot
);

  localparam int SW  = tabi_pkg::STAMP_W;
  localparam int MW  = tabi_pkg::MAG_W;
  localparam int CW  = $clog2(MW + 1);
  localparam int AW  = SW + 2;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [SW-1:0] rem;
  logic [MW-1:0] q;
  logic [MW-1:0] m;
  logic [SW-1:0] numr;
  logic [SW-1:0] denr;

  logic [AW-1:0] acc;
  logic [AW-1:0] den1;
  logic [AW-1:0] den2;
  logic [SW-1:0] rem_next;
  logic [MW-1:0] q_next;

  // invariant: q * den + rem == (mag bits so far) * num, rem < den
  always_comb begin
    acc  = {1'b0, rem, 1'b0} + (m[MW-1] ? {2'b00, numr} : '0);
    den1 = {2'b00, denr};
    den2 = {1'b0, denr, 1'b0};
    if (acc >= den2) begin
      rem_next = SW'(acc - den2);
      q_next   = {q[MW-2:0], 1'b0} + MW'(2);
    end else if (acc >= den1) begin
      rem_next = SW'(acc - den1);
      q_next   = {q[MW-2:0], 1'b0} + MW'(1);
    end else begin
      rem_next = SW'(acc);
      q_next   = {q[MW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(MW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem  <= '0;
      q    <= '0;
      m    <= mag;
      numr <= num;
      denr <= den;
    end else if (busy) begin
      rem <= rem_next;
      q   <= q_next;
      m   <= {m[MW-2:0], 1'b0};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quot        = q;

endmodule

>>> hdl/timestamped_angle_interpolation_buffer_top.sv
// ---------------------------------------------------------------------------
// timestamped_angle_interpolation_buffer_top
// ring store of timestamped headings with time lookup and interpolation
// ---------------------------------------------------------------------------
// A store item appends a sample (the oldest is overwritten when full). A
// query runs a binary search of up to ceil(log2(count+1)) probes, each a
// read of the sample memory and then a compare, plus a closing step that
// ends the search and fetches the edge or lower neighbor entry. An edge
// result then goes through the edge check and the emit state. An
// interpolated result fetches the neighbor pair, prepares the operands, runs
// the serial fraction unit (one bit of the 17-bit step magnitude per cycle,
// then a done pulse) and is emitted. A clean, if the count has reached the
// threshold, runs the same search on the cutoff time. One item is in work at
// a time; the finished result waits in an output register, and the block
// takes the next item as soon as that result has a free slot. Entries never
// written read as garbage; no clearing pass is needed.
// ---------------------------------------------------------------------------
module timestamped_angle_interpolation_buffer_top #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  tabi_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tabi_pkg::out_item_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [tabi_pkg::TOL_W-1:0]            cfg_data
);

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int CMW   = (CNT_W > tabi_pkg::LIM_W) ? CNT_W : tabi_pkg::LIM_W;
  localparam int SW    = tabi_pkg::STAMP_W;
  localparam int AGW   = tabi_pkg::ANGLE_W;
  localparam int MW    = tabi_pkg::MAG_W;
  localparam int TW    = tabi_pkg::TOL_W;
  localparam int LW    = tabi_pkg::LIM_W;
  localparam int EW    = SW + AGW;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SRCH   = 10'b0000000010,
    S_CMP    = 10'b0000000100,
    S_EDGE   = 10'b0000001000,
    S_PAIR1  = 10'b0000010000,
    S_PAIR2  = 10'b0000100000,
    S_DPREP  = 10'b0001000000,
    S_DCLAMP = 10'b0010000000,
    S_DIV    = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  // sample memory: {stamp, angle}, one read and one write port
  logic [EW-1:0]    mem [STORE_DEPTH];
  logic [EW-1:0]    rdata;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  state_t             state;
  logic [IDX_W-1:0]   oldest;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;
  logic [CNT_W-1:0]   mid;
  logic [SW-1:0]      key;
  logic               is_clean;
  logic [TW-1:0]      tol;
  logic [TW-1:0]      win;
  logic [LW-1:0]      thr;
  logic [LW-1:0]      keep;
  logic [SW-1:0]      t1;
  logic [SW-1:0]      t2;
  logic [AGW-1:0]     a1;
  logic [AGW-1:0]     a2;
  logic [SW-1:0]      den;
  logic [SW-1:0]      num;
  logic [MW-1:0]      mag;
  logic               neg;
  logic [AGW-1:0]     res_angle;
  logic [2:0]         res_code;
  tabi_pkg::out_item_t out_r;
  logic               out_v;

  logic               in_fire;
  logic [CNT_W-1:0]   mid_c;
  logic               full;
  logic               edge_first;
  logic [SW-1:0]      rd_stamp;
  logic [AGW-1:0]     rd_angle;
  logic [SW-1:0]      gap;
  logic [CNT_W-1:0]   drop;
  logic [CMW-1:0]     drop_w;
  logic signed [MW:0] raw;
  logic signed [MW:0] raw_w;
  logic [AGW-1:0]     step;
  logic               frac_start;
  tabi_pkg::frac_status_t frac_st;
  logic [MW-1:0]      frac_q;
  logic [SW-1:0]      num_cl;
  logic               emit_ok;

  // physical slot of a logical position, i <= STORE_DEPTH
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] i);
    logic [IDX_W+1:0] s;
    s = (IDX_W+2)'(base) + (IDX_W+2)'(i);
    if (s >= (IDX_W+2)'(STORE_DEPTH)) begin
      s = s - (IDX_W+2)'(STORE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign full      = (count == CNT_W'(STORE_DEPTH));
  assign mid_c     = lo + ((hi - lo) >> 1);
  assign rd_stamp  = rdata[EW-1:AGW];
  assign rd_angle  = rdata[AGW-1:0];
  assign edge_first = (count == CNT_W'(1)) || (lo == '0);
  assign emit_ok   = !out_v || out_ready;

  // drop count for clean: search index minus the old entries kept
  assign drop_w = CMW'(lo) - CMW'(keep);
  assign drop   = drop_w[CNT_W-1:0];

  // store write
  assign wr_en   = in_fire && (in_data.kind == tabi_pkg::KIND_STORE);
  assign wr_addr = full ? oldest : slot_of(oldest, count);

  // read address selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = slot_of(oldest, mid_c);
    unique case (state)
      S_SRCH: begin
        if (lo < hi) begin
          rd_en   = 1'b1;
          rd_addr = slot_of(oldest, mid_c);
        end else if (!is_clean) begin
          rd_en = 1'b1;
          if (edge_first) begin
            rd_addr = slot_of(oldest, '0);
          end else if (lo >= count) begin
            rd_addr = slot_of(oldest, count - CNT_W'(1));
          end else begin
            rd_addr = slot_of(oldest, lo - CNT_W'(1));
          end
        end
      end
      S_PAIR1: begin
        rd_en   = 1'b1;
        rd_addr = slot_of(oldest, lo);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_data.stamp_us, in_data.angle_in};
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // edge entry distance, absolute in both directions
  assign gap = (rd_stamp >= key) ? rd_stamp - key : key - rd_stamp;

  // short-way angle difference
  always_comb begin
    raw = $signed({2'b00, a2}) - $signed({2'b00, a1});
    raw_w = raw;
    if (raw > (MW+1)'(32768)) begin
      raw_w = raw - (MW+1)'(65536);
    end else if (raw < -(MW+1)'(32768)) begin
      raw_w = raw + (MW+1)'(65536);
    end
  end

  assign num_cl     = (num > den) ? den : num;
  assign frac_start = (state == S_DCLAMP);
  assign step       = frac_q[AGW-1:0];

  tabi_frac u_frac (
    .clk    (clk),
    .rst    (rst),
    .start  (frac_start),
    .mag    (mag),
    .num    (num_cl),
    .den    (den),
    .status (frac_st),
    .quot   (frac_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tol  <= TW'(200000);
      win  <= TW'(1000000);
      thr  <= LW'(1000);
      keep <= LW'(500);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tabi_pkg::REG_TOLERANCE: tol  <= cfg_data;
        tabi_pkg::REG_WINDOW:    win  <= cfg_data;
        tabi_pkg::REG_THRESHOLD: thr  <= cfg_data[LW-1:0];
        tabi_pkg::REG_KEEP:      keep <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      oldest <= '0;
      count  <= '0;
      out_v  <= 1'b0;
    end else begin
      // result register: loaded on emit, freed by the output transfer
      out_v <= (state == S_EMIT && emit_ok) || (out_v && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_data.kind)
              tabi_pkg::KIND_STORE: begin
                if (full) begin
                  oldest <= slot_of(oldest, CNT_W'(1));
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              tabi_pkg::KIND_QUERY: begin
                if (count == '0) begin
                  state <= S_EMIT;
                end else begin
                  state <= S_SRCH;
                end
              end
              tabi_pkg::KIND_CLEAN: begin
                if (CMW'(count) >= CMW'(thr)) begin
                  state <= S_SRCH;
                end
              end
              default: ;
            endcase
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            state <= S_CMP;
          end else if (is_clean) begin
            if (CMW'(lo) > CMW'(keep)) begin
              oldest <= slot_of(oldest, drop);
              count  <= count - drop;
            end
            state <= S_IDLE;
          end else if (edge_first || lo >= count) begin
            state <= S_EDGE;
          end else begin
            state <= S_PAIR1;
          end
        end
        S_CMP:    state <= S_SRCH;
        S_EDGE:   state <= S_EMIT;
        S_PAIR1:  state <= S_PAIR2;
        S_PAIR2:  state <= S_DPREP;
        S_DPREP:  state <= S_DCLAMP;
        S_DCLAMP: state <= S_DIV;
        S_DIV: begin
          if (frac_st.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        lo       <= '0;
        hi       <= count;
        is_clean <= (in_data.kind == tabi_pkg::KIND_CLEAN);
        res_angle <= '0;
        res_code  <= tabi_pkg::OUT_EMPTY;
        if (in_data.kind == tabi_pkg::KIND_CLEAN) begin
          // cutoff saturates at zero
          key <= (in_data.stamp_us >= SW'(win)) ? in_data.stamp_us - SW'(win) : '0;
        end else begin
          key <= in_data.stamp_us;
        end
      end
      S_SRCH: begin
        mid <= mid_c;
        res_code <= edge_first ? tabi_pkg::OUT_FIRST : tabi_pkg::OUT_LAST;
      end
      S_CMP: begin
        if (rd_stamp < key) begin
          lo <= mid + CNT_W'(1);
        end else begin
          hi <= mid;
        end
      end
      S_EDGE: begin
        if (gap < SW'(tol)) begin
          res_angle <= rd_angle;
        end else begin
          res_angle <= '0;
          res_code  <= tabi_pkg::OUT_TOL;
        end
      end
      S_PAIR1: begin
        t1 <= rd_stamp;
        a1 <= rd_angle;
      end
      S_PAIR2: begin
        t2 <= rd_stamp;
        a2 <= rd_angle;
      end
      S_DPREP: begin
        den <= (t2 > t1) ? t2 - t1 : SW'(1);
        num <= (key > t1) ? key - t1 : '0;
        mag <= raw_w[MW] ? MW'(-raw_w) : MW'(raw_w);
        neg <= raw_w[MW];
      end
      S_DIV: begin
        res_angle <= a1 + (neg ? AGW'(-step) : step);
        res_code  <= tabi_pkg::OUT_INTERP;
      end
      S_EMIT: begin
        if (emit_ok) begin
          out_r.angle_out <= res_angle;
          out_r.outcome   <= res_code;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_v;
  assign out_data  = out_r;

  // a query always ends in a result, so the sequencer leaves idle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.kind == tabi_pkg::KIND_QUERY |=> state != S_IDLE)
    else $error("query accepted but sequencer stayed idle");

  // an append to a store that is not full grows the count by one
  a_store_count: assert property (@(posedge clk) disable iff (rst)
    wr_en && !full |=> count == $past(count) + CNT_W'(1))
    else $error("store transfer did not grow entry count");

  // fraction unit finishes only while the sequencer waits for it
  a_frac_done: assert property (@(posedge clk) disable iff (rst)
    frac_st.done |-> state == S_DIV)
    else $error("fraction result outside division wait");

  // ring bookkeeping stays in range
  a_ring_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STORE_DEPTH) && (IDX_W+1)'(oldest) < (IDX_W+1)'(STORE_DEPTH))
    else $error("ring pointer or count out of range");

endmodule
